[rtl/core/adaptive_arithmetic_encoder_core_macros.svh]
// Assertion macros shared by the encoder core
`ifndef ADAPTIVE_ARITHMETIC_ENCODER_CORE_MACROS_SVH
`define ADAPTIVE_ARITHMETIC_ENCODER_CORE_MACROS_SVH

// Condition must never hold while out of reset
`define AAE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent on the following cycle
`define AAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/aae_pkg.sv]
// Shared types and constants for the adaptive arithmetic encoder
`timescale 1ns / 1ps
package aae_pkg;

	localparam int RANGE_BITS = 40;
	localparam int CNT_W      = 25;
	localparam int PEND_W     = 32;
	localparam int PROD_W     = 65;
	localparam int QUO_W      = RANGE_BITS + 1;

	localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(256);
	localparam logic [CNT_W-1:0] LIMIT_MAX   = CNT_W'(1) << 24;
	localparam logic [CNT_W-1:0] LIMIT_MIN   = CNT_W'(256);

	// opcodes
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// configuration register indexes
	localparam logic CFG_INCREMENT = 1'b0;
	localparam logic CFG_LIMIT     = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] symbol;
	} aae_in_t;

	typedef struct packed {
		logic              out_bit;
		logic [PEND_W-1:0] follow_count;
		logic              last;
	} aae_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic walk_start;
		logic walk_step;
		logic mul0;
		logic mul1;
		logic div_start;
		logic div_step;
		logic sel_b;
		logic save_qa;
		logic narrow;
		logic rn_step;
		logic rn_final;
		logic adapt;
		logic halve_start;
		logic halve_step;
		logic flush;
	} aae_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_last;
		logic div_last;
		logic rn_emit;
		logic rn_stop;
		logic hold_valid;
		logic out_free;
		logic over_limit;
		logic halve_last;
	} aae_stat_t;

endpackage

[rtl/core/aae_ctrl.sv]
// Sequencing state machine for the encoder
`timescale 1ns / 1ps
module aae_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                opcode,
	input  aae_pkg::aae_stat_t  st,
	output aae_pkg::aae_cmd_t   cmd,
	output logic                in_stall
);
	import aae_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WALK   = 4'd1;
	localparam logic [3:0] ST_WDRAIN = 4'd2;
	localparam logic [3:0] ST_MUL0   = 4'd3;
	localparam logic [3:0] ST_MUL1   = 4'd4;
	localparam logic [3:0] ST_DIV    = 4'd5;
	localparam logic [3:0] ST_QSAVE  = 4'd6;
	localparam logic [3:0] ST_RENORM = 4'd7;
	localparam logic [3:0] ST_ADAPT  = 4'd8;
	localparam logic [3:0] ST_HCHK   = 4'd9;
	localparam logic [3:0] ST_HALVE  = 4'd10;
	localparam logic [3:0] ST_HDRAIN = 4'd11;
	localparam logic [3:0] ST_FLUSH  = 4'd12;

	logic [3:0] state_q, state_n;
	logic       phase_b_q, phase_b_n;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_n   = state_q;
		phase_b_n = phase_b_q;
		cmd.sel_b = phase_b_q;
		unique case (state_q)
			ST_IDLE: begin
				phase_b_n = 1'b0;
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.walk_start = 1'b1;
					state_n = (opcode == OP_FLUSH) ? ST_FLUSH : ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_last)
					state_n = ST_WDRAIN;
			end
			ST_WDRAIN: state_n = ST_MUL0;
			ST_MUL0: begin
				cmd.mul0      = 1'b1;
				cmd.div_start = 1'b1;
				state_n = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last)
					state_n = ST_QSAVE;
			end
			ST_QSAVE: begin
				if (!phase_b_q) begin
					cmd.save_qa = 1'b1;
					phase_b_n = 1'b1;
					state_n = ST_MUL0;
				end else begin
					cmd.narrow = 1'b1;
					state_n = ST_RENORM;
				end
			end
			ST_RENORM: begin
				if (st.rn_stop) begin
					if (!st.hold_valid) begin
						state_n = ST_ADAPT;
					end else if (st.out_free) begin
						cmd.rn_final = 1'b1;
						state_n = ST_ADAPT;
					end
				end else if (!(st.rn_emit && st.hold_valid && !st.out_free)) begin
					cmd.rn_step = 1'b1;
				end
			end
			ST_ADAPT: begin
				cmd.adapt = 1'b1;
				state_n = ST_HCHK;
			end
			ST_HCHK: begin
				if (st.over_limit) begin
					cmd.halve_start = 1'b1;
					state_n = ST_HALVE;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_HALVE: begin
				cmd.halve_step = 1'b1;
				if (st.halve_last)
					state_n = ST_HDRAIN;
			end
			ST_HDRAIN: state_n = ST_HCHK;
			ST_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_b_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			phase_b_q <= phase_b_n;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[rtl/core/aae_dp.sv]
// Encoder datapath: count memory, multiplier, divider, interval and output
`timescale 1ns / 1ps
module aae_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aae_pkg::aae_cmd_t     cmd,
	output aae_pkg::aae_stat_t    st,
	input  aae_pkg::aae_in_t      in_req,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [24:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output aae_pkg::aae_out_t     out_req
);
	import aae_pkg::*;

	localparam logic [RANGE_BITS-1:0] HALF = RANGE_BITS'(1) << (RANGE_BITS - 1);
	localparam logic [RANGE_BITS-1:0] QTR  = RANGE_BITS'(1) << (RANGE_BITS - 2);
	localparam logic [PEND_W-1:0]     PEND_MAX = '1;

	// configuration
	logic [15:0]      inc_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] lim_eff;

	// coder state
	logic [RANGE_BITS-1:0] low_q, high_q;
	logic [PEND_W-1:0]     pend_q;
	logic [CNT_W-1:0]      total_q;
	logic [7:0]            sym_q;

	// count memory with per-entry valid bits
	logic [CNT_W-1:0] mem [256];
	logic [255:0]     vld_q;
	logic [CNT_W-1:0] rd_data_s1;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] rd_eff, halved;
	logic             wr_en;
	logic [7:0]       wr_addr;
	logic [CNT_W-1:0] wr_data;

	// walk and sweep
	logic [7:0]       j_q;
	logic [7:0]       addr_s1;
	logic             walk_s1, last_s1, halve_s1;
	logic [CNT_W-1:0] cum_q, cnt_sym_q, cum_b, c_sel;

	// scaling
	logic [RANGE_BITS:0]   range;
	logic [20:0]           mop;
	logic [45:0]           mp;
	logic [PROD_W-1:0]     prod_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W:0]        rem_n, tot_x, diff;
	logic                  ge;
	logic [QUO_W-1:0]      quo_q, qa_q;
	logic [6:0]            dcnt_q;

	// renormalisation
	logic [5:0]            it_q;
	logic                  emit0, emit1, under;
	logic [RANGE_BITS-1:0] sub, ln, hn;
	logic                  hold_valid_q;
	aae_out_t              hold_q;
	logic                  out_valid_q;
	aae_out_t              out_q;
	logic                  push;
	aae_out_t              push_data;
	logic                  out_free;
	logic [PEND_W-1:0]     pend_inc;

	// effective halving limit
	always_comb begin
		lim_eff = limit_q;
		if (limit_q > LIMIT_MAX)
			lim_eff = LIMIT_MAX;
		if (limit_q < LIMIT_MIN)
			lim_eff = LIMIT_MIN;
	end

	assign pend_inc = (pend_q == PEND_MAX) ? pend_q : pend_q + PEND_W'(1);

	// memory read value, unwritten entries count as one
	assign rd_eff = rd_vld_s1 ? rd_data_s1 : CNT_W'(1);
	assign halved = (rd_eff[CNT_W-1:1] == '0) ? CNT_W'(1) : {1'b0, rd_eff[CNT_W-1:1]};

	assign wr_en   = cmd.adapt || halve_s1;
	assign wr_addr = cmd.adapt ? sym_q : addr_s1;
	assign wr_data = cmd.adapt ? cnt_sym_q + CNT_W'(inc_q) : halved;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[j_q];
			if (cmd.flush)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
		end
	end

	// multiplier operands, range split in two halves
	assign range = {1'b0, high_q} - {1'b0, low_q} + (RANGE_BITS+1)'(1);
	assign cum_b = cum_q + cnt_sym_q;
	assign c_sel = cmd.sel_b ? cum_b : cum_q;
	assign mop   = cmd.mul1 ? range[40:20] : {1'b0, range[19:0]};
	assign mp    = c_sel * mop;

	// restoring division step
	assign rem_n = {rem_q, prod_q[PROD_W-1]};
	assign tot_x = {1'b0, total_q};
	assign ge    = (rem_n >= tot_x);
	assign diff  = rem_n - tot_x;

	// renormalisation decision
	assign emit0 = !high_q[RANGE_BITS-1];
	assign emit1 = !emit0 && low_q[RANGE_BITS-1];
	assign under = !emit0 && !emit1 && low_q[RANGE_BITS-2] && !high_q[RANGE_BITS-2];
	assign sub   = emit1 ? HALF : (under ? QTR : '0);
	assign ln    = low_q - sub;
	assign hn    = high_q - sub;

	assign out_free = !out_valid_q || !out_stall;

	// results into the output register
	always_comb begin
		push      = 1'b0;
		push_data = hold_q;
		if (cmd.flush) begin
			push = 1'b1;
			push_data.out_bit      = (low_q >= QTR);
			push_data.follow_count = pend_inc;
			push_data.last         = 1'b1;
		end else if (cmd.rn_final) begin
			push = 1'b1;
			push_data.last = 1'b1;
		end else if (cmd.rn_step && (emit0 || emit1) && hold_valid_q) begin
			push = 1'b1;
			push_data.last = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q        <= 16'd500;
			limit_q      <= LIMIT_MAX;
			low_q        <= '0;
			high_q       <= '1;
			pend_q       <= '0;
			total_q      <= TOTAL_RESET;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			walk_s1      <= 1'b0;
			halve_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INCREMENT: inc_q   <= cfg_data[15:0];
					CFG_LIMIT:     limit_q <= cfg_data;
					default:       ;
				endcase
			end
			walk_s1  <= cmd.walk_step;
			halve_s1 <= cmd.halve_step;

			if (push)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cmd.flush) begin
				low_q   <= '0;
				high_q  <= '1;
				pend_q  <= '0;
				total_q <= TOTAL_RESET;
			end else if (cmd.narrow) begin
				low_q  <= low_q + qa_q[RANGE_BITS-1:0];
				high_q <= low_q + quo_q[RANGE_BITS-1:0] - RANGE_BITS'(1);
			end else if (cmd.rn_step) begin
				low_q  <= {ln[RANGE_BITS-2:0], 1'b0};
				high_q <= {hn[RANGE_BITS-2:0], 1'b1};
				if (emit0 || emit1) begin
					pend_q       <= '0;
					hold_valid_q <= 1'b1;
				end else begin
					pend_q <= pend_inc;
				end
			end else if (cmd.rn_final) begin
				hold_valid_q <= 1'b0;
			end

			if (cmd.adapt)
				total_q <= total_q + CNT_W'(inc_q);
			else if (cmd.halve_start)
				total_q <= '0;
			else if (halve_s1)
				total_q <= total_q + halved;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			sym_q <= in_req.symbol;
		if (push)
			out_q <= push_data;
		if (cmd.rn_step && (emit0 || emit1)) begin
			hold_q.out_bit      <= emit1;
			hold_q.follow_count <= pend_q;
			hold_q.last         <= 1'b0;
		end

		// index for walk and sweep
		if (cmd.walk_start || cmd.halve_start)
			j_q <= '0;
		else if (cmd.walk_step || cmd.halve_step)
			j_q <= j_q + 8'd1;
		addr_s1 <= j_q;
		last_s1 <= (j_q == sym_q);

		// cumulative count walk
		if (cmd.walk_start)
			cum_q <= '0;
		else if (walk_s1) begin
			if (last_s1)
				cnt_sym_q <= rd_eff;
			else
				cum_q <= cum_q + rd_eff;
		end

		// product in two partial steps, then shift-subtract division
		if (cmd.mul0)
			prod_q <= PROD_W'(mp);
		else if (cmd.mul1)
			prod_q <= prod_q + {mp[44:0], 20'b0};
		else if (cmd.div_step)
			prod_q <= {prod_q[PROD_W-2:0], 1'b0};

		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[CNT_W-1:0] : rem_n[CNT_W-1:0];
			quo_q  <= {quo_q[QUO_W-2:0], ge};
			dcnt_q <= dcnt_q + 7'd1;
		end

		if (cmd.save_qa)
			qa_q <= quo_q;

		if (cmd.narrow)
			it_q <= '0;
		else if (cmd.rn_step)
			it_q <= it_q + 6'd1;
	end

	assign st.walk_last  = (j_q == sym_q);
	assign st.div_last   = (dcnt_q == 7'(PROD_W - 1));
	assign st.rn_emit    = emit0 || emit1;
	assign st.rn_stop    = (it_q == 6'(RANGE_BITS)) || !(emit0 || emit1 || under);
	assign st.hold_valid = hold_valid_q;
	assign st.out_free   = out_free;
	assign st.over_limit = (total_q > lim_eff);
	assign st.halve_last = (j_q == 8'hFF);

	assign out_valid = out_valid_q;
	assign out_req   = out_q;

endmodule

[rtl/core/adaptive_arithmetic_encoder_core.sv]
// Top level of the order-0 adaptive arithmetic encoder
`timescale 1ns / 1ps
`include "adaptive_arithmetic_encoder_core_macros.svh"
// Order-0 adaptive byte encoder with a 40-bit interval. One request is taken
// at a time. An encode request sums the cumulative counts (one count memory
// read a cycle), computes the two slice ends (two-step multiply plus a
// 65-step bit-serial divider), renormalises the interval (held while the
// result side stalls) and then updates the counts. When the total passes the
// limit a halving sweep over the count memory follows, repeated until the
// total is back within it. A flush waits for the output register to be
// free. Counts, total, interval and pending bits are at their initial values
// straight after reset.
module adaptive_arithmetic_encoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  aae_pkg::aae_in_t    in_req,
	output logic                out_valid,
	input  logic                out_stall,
	output aae_pkg::aae_out_t   out_req,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [24:0]         cfg_data
);
	import aae_pkg::*;

	aae_cmd_t  cmd;
	aae_stat_t st;

	aae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_req.opcode),
		.st       (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	aae_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_req    (in_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	// a result is only loaded when the output register can take it
	`AAE_ASSERT_NEVER(a_push_free, (cmd.flush || cmd.rn_final || (cmd.rn_step && st.rn_emit && st.hold_valid)) && !st.out_free, "result pushed into busy output register")
	// an accepted request blocks the input side on the next cycle
	`AAE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not blocked after accept")
	// no held result may remain once the block is idle
	`AAE_ASSERT_NEVER(a_hold_idle, !in_stall && st.hold_valid, "held result left behind at idle")

endmodule

[bench/tb_adaptive_arithmetic_encoder_core.sv]
// Self-checking testbench for the adaptive arithmetic encoder core
`timescale 1ns / 1ps
module tb_adaptive_arithmetic_encoder_core;
	import aae_pkg::*;

	localparam int SETTLE_CYCLES = 4000;
	localparam logic [39:0] IV_MASK = 40'hFF_FFFF_FFFF;
	localparam logic [39:0] IV_HALF = 40'h80_0000_0000;
	localparam logic [39:0] IV_QTR  = 40'h40_0000_0000;
	localparam logic [39:0] IV_3QTR = 40'hC0_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	aae_in_t     in_req = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	aae_out_t    out_req;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_INCREMENT;
	logic [24:0] cfg_data = '0;

	adaptive_arithmetic_encoder_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// coder state mirror
	int unsigned sym_count [256];
	logic [31:0] count_sum;
	logic [39:0] iv_low, iv_high;
	logic [31:0] pend_run;
	logic [15:0] inc_reg;
	logic [24:0] limit_reg;

	aae_out_t code_groups[$];   // expected bit groups, oldest first
	aae_out_t fresh_groups[$];  // groups produced by the latest request
	int errors = 0;
	int groups_seen = 0;
	int requests_sent = 0;
	int flushes_sent = 0;
	bit gaps_on = 1'b1;
	bit long_hold = 1'b0;

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic void clear_coder();
		foreach (sym_count[j]) sym_count[j] = 1;
		count_sum = 256;
		iv_low = '0;
		iv_high = IV_MASK;
		pend_run = '0;
	endfunction

	function automatic void bump_pending();
		if (pend_run != 32'hFFFF_FFFF) pend_run++;
	endfunction

	function automatic void add_group(input logic b);
		aae_out_t g;
		g.out_bit = b;
		g.follow_count = pend_run;
		g.last = 1'b0;
		fresh_groups.push_back(g);
		pend_run = '0;
	endfunction

	// floor(c * r / t), exact
	function automatic logic [63:0] slice_end(input logic [63:0] c, input logic [63:0] r,
			input logic [63:0] t);
		logic [127:0] p;
		p = {64'd0, c} * {64'd0, r};
		return 64'(p / {64'd0, t});
	endfunction

	// bit groups for one request, into fresh_groups
	function automatic void code_request(input aae_in_t r);
		logic [63:0] cum_a, span, lo, hi, lim, sum;
		int unsigned v;
		fresh_groups.delete();
		if (r.opcode == OP_FLUSH) begin
			bump_pending();
			add_group(iv_low >= IV_QTR);
			fresh_groups[$].last = 1'b1;
			clear_coder();
			return;
		end
		cum_a = 0;
		for (int j = 0; j < r.symbol; j++) cum_a += 64'(sym_count[j]);
		span = ({24'd0, iv_high} - {24'd0, iv_low} + 64'd1) & 64'h1FF_FFFF_FFFF;
		lo = ({24'd0, iv_low} + slice_end(cum_a, span, 64'(count_sum))) & IV_MASK;
		hi = ({24'd0, iv_low} + slice_end(cum_a + 64'(sym_count[r.symbol]), span,
			64'(count_sum)) - 64'd1) & IV_MASK;
		// renormalise
		for (int k = 0; k < 40; k++) begin
			if (hi < IV_HALF) begin
				add_group(1'b0);
			end else if (lo >= IV_HALF) begin
				add_group(1'b1);
				lo -= IV_HALF;
				hi -= IV_HALF;
			end else if (lo >= IV_QTR && hi < IV_3QTR) begin
				bump_pending();
				lo -= IV_QTR;
				hi -= IV_QTR;
			end else begin
				break;
			end
			lo = (lo << 1) & IV_MASK;
			hi = ((hi << 1) | 64'd1) & IV_MASK;
		end
		iv_low = lo[39:0];
		iv_high = hi[39:0];
		// adapt counts, halving with a floor of one
		lim = 64'(limit_reg);
		if (lim > 64'(LIMIT_MAX)) lim = 64'(LIMIT_MAX);
		if (lim < 64'(LIMIT_MIN)) lim = 64'(LIMIT_MIN);
		sym_count[r.symbol] += 32'(inc_reg);
		count_sum += 32'(inc_reg);
		while (64'(count_sum) > lim) begin
			sum = 0;
			foreach (sym_count[j]) begin
				v = sym_count[j] >> 1;
				if (v == 0) v = 1;
				sym_count[j] = v;
				sum += 64'(v);
			end
			count_sum = sum[31:0];
		end
		if (fresh_groups.size() > 0) fresh_groups[$].last = 1'b1;
	endfunction

	// offer one request, predict on acceptance
	task automatic send_request(input aae_in_t r, input bit typed, input aae_out_t want);
		int gap;
		gap = gaps_on ? $urandom_range(19, 0) : 0;
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (in_stall);
		code_request(r);
		if (typed) code_groups.push_back(want);
		else foreach (fresh_groups[i]) code_groups.push_back(fresh_groups[i]);
		requests_sent++;
		if (r.opcode == OP_FLUSH) flushes_sent++;
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (code_groups.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [24:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk) cfg_we <= 1'b0;
		if (idx == CFG_INCREMENT) inc_reg = val[15:0];
		else limit_reg = val;
	endtask

	function automatic aae_in_t random_request();
		aae_in_t r;
		int pick;
		pick = $urandom_range(99, 0);
		r.opcode = (pick < 4) ? OP_FLUSH : OP_ENCODE;
		if (pick < 50) r.symbol = 8'($urandom_range(3, 0) * 37 + 60);  // skewed source
		else if (pick < 60) r.symbol = ($urandom_range(1, 0) != 0) ? 8'd255 : 8'd0;
		else r.symbol = 8'($urandom);
		return r;
	endfunction

	// result side: random stalls, one long hold on request
	initial begin
		int n;
		forever begin
			n = gaps_on ? $urandom_range(19, 0) : 0;
			if (long_hold) begin
				long_hold = 1'b0;
				n = 2500;
			end
			if (n > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end else begin
				@(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			groups_seen++;
			if (code_groups.size() == 0) begin
				report("unexpected group", out_req.follow_count, 0);
			end else begin
				aae_out_t w;
				w = code_groups.pop_front();
				if (out_req.out_bit !== w.out_bit) report("out_bit", out_req.out_bit, w.out_bit);
				if (out_req.follow_count !== w.follow_count)
					report("follow_count", out_req.follow_count, w.follow_count);
				if (out_req.last !== w.last) report("last", out_req.last, w.last);
			end
		end
	end

	// directed rows: opcode, symbol, typed flag, typed result
	typedef struct {
		logic     op;
		logic [7:0] sym;
		bit       typed;
		aae_out_t want;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{OP_FLUSH,  8'd0,   1, '{1'b0, 32'd1, 1'b1}},  // flush straight after reset
		'{OP_FLUSH,  8'd77,  1, '{1'b0, 32'd1, 1'b1}},  // symbol ignored on flush
		'{OP_ENCODE, 8'd0,   0, '0},
		'{OP_ENCODE, 8'd255, 0, '0},
		'{OP_ENCODE, 8'd128, 0, '0},
		'{OP_ENCODE, 8'd127, 0, '0},
		'{OP_ENCODE, 8'd128, 0, '0},
		'{OP_ENCODE, 8'd255, 0, '0},
		'{OP_ENCODE, 8'd255, 0, '0},
		'{OP_ENCODE, 8'd0,   0, '0},
		'{OP_ENCODE, 8'hAA,  0, '0},
		'{OP_ENCODE, 8'h55,  0, '0},
		'{OP_FLUSH,  8'hFF,  0, '0},
		'{OP_ENCODE, 8'd1,   0, '0},
		'{OP_ENCODE, 8'd1,   0, '0},
		'{OP_ENCODE, 8'd1,   0, '0},
		'{OP_FLUSH,  8'd0,   0, '0}
	};

	// register settings per phase: increment, limit
	logic [15:0] phase_inc[] = '{16'd1, 16'd65535, 16'd65535, 16'd200, 16'd7, 16'd500};
	logic [24:0] phase_lim[] = '{25'd256, 25'd300, 25'd0, 25'h1FF_FFFF, 25'd1000,
		25'h100_0000};

	initial begin
		aae_in_t r;
		inc_reg = 16'd500;
		limit_reg = 25'h100_0000;
		clear_coder();
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			r.opcode = dir_rows[i].op;
			r.symbol = dir_rows[i].sym;
			send_request(r, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < phase_inc.size(); p++) begin
			drain();
			write_reg(CFG_INCREMENT, {9'd0, phase_inc[p]});
			write_reg(CFG_LIMIT, phase_lim[p]);
			gaps_on = (p != 2);
			if (p == 1) long_hold = 1'b1;
			for (int k = 0; k < 66; k++) send_request(random_request(), 1'b0, '0);
		end

		drain();
		$display("covered %0d requests (%0d flushes), %0d bit groups checked,",
			requests_sent, flushes_sent, groups_seen);
		$display("across %0d register settings including saturated limits", phase_inc.size());
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout with %0d groups outstanding", code_groups.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/aae_pkg.sv
rtl/core/aae_ctrl.sv
rtl/core/aae_dp.sv
rtl/core/adaptive_arithmetic_encoder_core.sv
bench/tb_adaptive_arithmetic_encoder_core.sv
